// ----- hdl/ttsq_pkg.sv -----
// Shared types, constants and helpers for the timed transmit slot queue.
// Depends on nothing; imported by timed_tx_slot_queue_unit.
`timescale 1ns / 1ps

package ttsq_pkg;

   // Queue depth and derived widths
   localparam int DEPTH   = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SLOT_W  = 5;
   localparam int WIDE_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int OUT_W   = 6;
   localparam int SAT_W   = (CNT_W > OUT_W) ? CNT_W : OUT_W;

   // Field widths
   localparam int TIME_W  = 48;
   localparam int AIR_W   = 24;
   localparam int KIND_W  = 2;
   localparam int TAG_W   = 8;
   localparam int DLY_W   = 20;
   localparam int ADV_W   = 24;
   localparam int CSR_W   = 24;
   localparam int CSR_A_W = 3;
   localparam int PM_W    = DLY_W + 2;
   localparam int LIM_W   = AIR_W + 1;

   // Register reset values
   localparam logic [DLY_W-1:0] START_DELAY_RST = DLY_W'(1500);
   localparam logic [DLY_W-1:0] JIT_DELAY_RST   = DLY_W'(10000);
   localparam logic [DLY_W-1:0] MARGIN_RST      = DLY_W'(1000);
   localparam logic [ADV_W-1:0] MAX_ADVANCE_RST = ADV_W'(6000000);
   localparam logic [DLY_W-1:0] DEVIATION_RST   = DLY_W'(500);

   typedef enum logic [CSR_A_W-1:0] {
      REG_START_DELAY = 3'd0,
      REG_JIT_DELAY   = 3'd1,
      REG_MARGIN      = 3'd2,
      REG_MAX_ADVANCE = 3'd3,
      REG_DEVIATION   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_ENQ  = 2'd0,
      CMD_PEEK = 2'd1,
      CMD_DEQ  = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_FULL   = 3'd2,
      ST_LATE   = 3'd3,
      ST_EARLY  = 3'd4,
      ST_COLL   = 3'd5,
      ST_BADIDX = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DECIDE,
      S_MOVE,
      S_FINISH,
      S_RESP
   } state_type;

   // One stored packet
   typedef struct packed {
      logic [TIME_W-1:0] send_time;
      logic [AIR_W-1:0]  airtime;
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  tag;
   } slot_type;

   // Clamp a count to the 6-bit result fields
   function automatic logic [OUT_W-1:0] sat63(input logic [CNT_W-1:0] v);
      logic [SAT_W-1:0] w;
      w = SAT_W'(v);
      return (w > SAT_W'(63)) ? OUT_W'(63) : w[OUT_W-1:0];
   endfunction

endpackage

// ----- hdl/timed_tx_slot_queue_unit.sv -----
// Top level of the timed transmit slot queue: FSM, slot memory, scan and shift.
// Depends on ttsq_pkg.
`timescale 1ns / 1ps

// Usage:
//  Commands enter on req_* and are taken at a clock edge with start high and
//  busy low. cmd 0 enqueues a timed packet, 1 purges past packets and peeks
//  the head, 2 removes the entry at a sorted index, 3 does nothing.
//  Each command yields one result on rsp_*, shown for one cycle with rsp_valid
//  high; the receiver must take it then, there is no back-pressure.
//  The csr_* port writes the five timing registers. The user must write them
//  only while the block is idle; the block itself does not enforce it. Errors
//  found on the inputs alone answer from the check state without a scan.
//  Otherwise the slot memory (one read, one write port, registered read) is
//  scanned once over all N held entries; a collision answers after the scan.
//  Else entries are shifted one per cycle for M moves before the result. One
//  command is worked at a time; busy stays high until the result cycle ends.
//  Reset empties the queue and loads the default register values; the slot
//  memory itself is not cleared, entries at or beyond the fill level are
//  never used.
module timed_tx_slot_queue_unit
   import ttsq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_cmd,
   input  logic [TIME_W-1:0]    req_now_us,
   input  logic [TIME_W-1:0]    req_send_time_us,
   input  logic [AIR_W-1:0]     req_airtime_us,
   input  logic [KIND_W-1:0]    req_kind_in,
   input  logic [TAG_W-1:0]     req_tag_in,
   input  logic [SLOT_W-1:0]    req_slot_index,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic                 rsp_head_ready,
   output logic [OUT_W-1:0]     rsp_dropped_count,
   output logic [TAG_W-1:0]     rsp_tag_out,
   output logic [KIND_W-1:0]    rsp_kind_out,
   output logic [OUT_W-1:0]     rsp_fill_level,
   input  logic                 csr_we,
   input  logic [CSR_A_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   state_type state_ff, state_in;

   // Configuration registers
   logic [DLY_W-1:0] start_dly_ff, jit_dly_ff, margin_ff, dev_ff;
   logic [ADV_W-1:0] adv_ff;

   // Captured command
   cmd_type           cmd_ff;
   logic [TIME_W-1:0] now_ff, time_ff;
   logic [AIR_W-1:0]  air_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SLOT_W-1:0] idx_ff;

   // Queue bookkeeping and scan results
   logic [CNT_W-1:0]  count_ff, scan_ff, pos_ff, drop_ff, mv_left_ff, shamt_ff;
   logic [CNT_W-1:0]  sc_idx_ff;
   logic              sc_vld_ff, coll_ff, ready_ff, hd_seen_ff, mv_vld_ff, up_ff;
   logic [IDX_W-1:0]  src_ff, mv_dst_ff;
   logic [PM_W-1:0]   pm_ff;
   logic [LIM_W-1:0]  lim_new_ff;
   status_type        st_ff;
   logic [KIND_W-1:0] kind_o_ff;
   logic [TAG_W-1:0]  tag_o_ff;

   // Slot memory
   slot_type          slot_mem [DEPTH];
   slot_type          rdata_ff, wdata;
   logic [IDX_W-1:0]  raddr, waddr;
   logic              mem_we;

   // Combinational checks
   logic [TIME_W:0]   late_lim, early_lim;
   logic              is_late, is_early, idx_bad;
   logic              scan_more, e_coll, e_le, e_lt, e_ready;
   logic [LIM_W-1:0]  lim_old;
   logic [TIME_W-1:0] d_old_new, d_new_old, d_head;

   // Input bound checks
   always_comb begin
      late_lim  = {1'b0, now_ff} + (TIME_W+1)'(margin_ff) + (TIME_W+1)'(jit_dly_ff);
      early_lim = {1'b0, now_ff} + (TIME_W+1)'(adv_ff);
      is_late   = ({1'b0, time_ff} <= late_lim);
      is_early  = ({1'b0, time_ff} >= early_lim);
      idx_bad   = (WIDE_W'(idx_ff) >= WIDE_W'(count_ff));
      scan_more = (scan_ff < count_ff);
   end

   // Per-entry evaluation on the registered read data
   always_comb begin
      d_old_new = rdata_ff.send_time - time_ff;
      d_new_old = time_ff - rdata_ff.send_time;
      d_head    = rdata_ff.send_time - now_ff;
      lim_old   = LIM_W'(pm_ff) + LIM_W'(rdata_ff.airtime);
      if (time_ff <= rdata_ff.send_time) begin
         e_coll = (d_old_new <= TIME_W'(lim_new_ff));
      end else begin
         e_coll = (d_new_old <= TIME_W'(lim_old));
      end
      e_le    = (rdata_ff.send_time <= time_ff);
      e_lt    = (rdata_ff.send_time < now_ff);
      e_ready = (d_head < TIME_W'(dev_ff));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_CHECK;
         end
         S_CHECK: begin
            priority case (cmd_ff)
               CMD_ENQ: begin
                  if ((count_ff >= CNT_W'(DEPTH)) || is_late || is_early) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               CMD_PEEK: state_in = (count_ff == '0) ? S_RESP : S_SCAN;
               CMD_DEQ: begin
                  state_in = ((count_ff == '0) || idx_bad) ? S_RESP : S_SCAN;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_SCAN: begin
            if (!scan_more && !sc_vld_ff) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = (cmd_ff == CMD_ENQ && coll_ff) ? S_RESP : S_MOVE;
         end
         S_MOVE: begin
            if (mv_left_ff == '0 && !mv_vld_ff) state_in = S_FINISH;
         end
         S_FINISH: state_in = S_RESP;
         S_RESP:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Outputs and memory port control
   always_comb begin
      busy              = (state_ff != S_IDLE);
      rsp_valid         = (state_ff == S_RESP);
      rsp_status        = st_ff;
      rsp_head_ready    = ready_ff;
      rsp_dropped_count = sat63(drop_ff);
      rsp_tag_out       = tag_o_ff;
      rsp_kind_out      = kind_o_ff;
      rsp_fill_level    = sat63(count_ff);
      raddr             = (state_ff == S_MOVE) ? src_ff : scan_ff[IDX_W-1:0];
      if (state_ff == S_FINISH) begin
         mem_we = (cmd_ff == CMD_ENQ);
         waddr  = pos_ff[IDX_W-1:0];
         wdata  = '{send_time: time_ff, airtime: air_ff, kind: kind_ff, tag: tag_ff};
      end else begin
         mem_we = (state_ff == S_MOVE) && mv_vld_ff;
         waddr  = mv_dst_ff;
         wdata  = rdata_ff;
      end
   end

   // Slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[waddr] <= wdata;
      rdata_ff <= slot_mem[raddr];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_dly_ff <= START_DELAY_RST;
         jit_dly_ff   <= JIT_DELAY_RST;
         margin_ff    <= MARGIN_RST;
         adv_ff       <= MAX_ADVANCE_RST;
         dev_ff       <= DEVIATION_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_START_DELAY: start_dly_ff <= csr_wdata[DLY_W-1:0];
            REG_JIT_DELAY:   jit_dly_ff   <= csr_wdata[DLY_W-1:0];
            REG_MARGIN:      margin_ff    <= csr_wdata[DLY_W-1:0];
            REG_MAX_ADVANCE: adv_ff       <= csr_wdata[ADV_W-1:0];
            REG_DEVIATION:   dev_ff       <= csr_wdata[DLY_W-1:0];
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         sc_vld_ff <= 1'b0;
         mv_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sc_vld_ff <= (state_ff == S_SCAN) && scan_more;
         mv_vld_ff <= (state_ff == S_MOVE) && (mv_left_ff != '0);
         if (state_ff == S_FINISH) begin
            unique case (cmd_ff)
               CMD_ENQ:  count_ff <= count_ff + CNT_W'(1);
               CMD_PEEK: count_ff <= count_ff - drop_ff;
               CMD_DEQ:  count_ff <= count_ff - CNT_W'(1);
               default:  count_ff <= count_ff;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            cmd_ff     <= cmd_type'(req_cmd);
            now_ff     <= req_now_us;
            time_ff    <= req_send_time_us;
            air_ff     <= req_airtime_us;
            kind_ff    <= req_kind_in;
            tag_ff     <= req_tag_in;
            idx_ff     <= req_slot_index;
            st_ff      <= ST_OK;
            coll_ff    <= 1'b0;
            ready_ff   <= 1'b0;
            hd_seen_ff <= 1'b0;
            pos_ff     <= '0;
            drop_ff    <= '0;
            scan_ff    <= '0;
            tag_o_ff   <= '0;
            kind_o_ff  <= '0;
            mv_left_ff <= '0;
         end
         S_CHECK: begin
            pm_ff      <= PM_W'(start_dly_ff) + PM_W'(jit_dly_ff) + PM_W'(margin_ff);
            lim_new_ff <= LIM_W'(start_dly_ff) + LIM_W'(jit_dly_ff) + LIM_W'(margin_ff)
                          + LIM_W'(air_ff);
            priority case (cmd_ff)
               CMD_ENQ: begin
                  if (count_ff >= CNT_W'(DEPTH)) st_ff <= ST_FULL;
                  else if (is_late)              st_ff <= ST_LATE;
                  else if (is_early)             st_ff <= ST_EARLY;
               end
               CMD_PEEK: begin
                  if (count_ff == '0) st_ff <= ST_EMPTY;
               end
               CMD_DEQ: begin
                  if (count_ff == '0) st_ff <= ST_EMPTY;
                  else if (idx_bad)   st_ff <= ST_BADIDX;
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            if (scan_more) scan_ff <= scan_ff + CNT_W'(1);
            sc_idx_ff <= scan_ff;
            // evaluate the entry read on the previous cycle
            if (sc_vld_ff) begin
               unique case (cmd_ff)
                  CMD_ENQ: begin
                     if (e_coll) coll_ff <= 1'b1;
                     if (e_le)   pos_ff  <= pos_ff + CNT_W'(1);
                  end
                  CMD_PEEK: begin
                     if (e_lt) begin
                        drop_ff <= drop_ff + CNT_W'(1);
                     end else if (!hd_seen_ff) begin
                        hd_seen_ff <= 1'b1;
                        ready_ff   <= e_ready;
                     end
                  end
                  CMD_DEQ: begin
                     if (WIDE_W'(sc_idx_ff) == WIDE_W'(idx_ff)) begin
                        tag_o_ff  <= rdata_ff.tag;
                        kind_o_ff <= rdata_ff.kind;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DECIDE: begin
            // set up the shift pass
            unique case (cmd_ff)
               CMD_ENQ: begin
                  if (coll_ff) st_ff <= ST_COLL;
                  mv_left_ff <= count_ff - pos_ff;
                  src_ff     <= IDX_W'(count_ff - CNT_W'(1));
                  up_ff      <= 1'b1;
                  shamt_ff   <= CNT_W'(1);
               end
               CMD_PEEK: begin
                  if (drop_ff == count_ff) st_ff <= ST_EMPTY;
                  mv_left_ff <= count_ff - drop_ff;
                  src_ff     <= drop_ff[IDX_W-1:0];
                  up_ff      <= 1'b0;
                  shamt_ff   <= drop_ff;
               end
               default: begin
                  mv_left_ff <= count_ff - CNT_W'(idx_ff) - CNT_W'(1);
                  src_ff     <= IDX_W'(CNT_W'(idx_ff) + CNT_W'(1));
                  up_ff      <= 1'b0;
                  shamt_ff   <= CNT_W'(1);
               end
            endcase
         end
         S_MOVE: begin
            if (mv_left_ff != '0) begin
               mv_left_ff <= mv_left_ff - CNT_W'(1);
               if (up_ff) begin
                  mv_dst_ff <= src_ff + IDX_W'(1);
                  src_ff    <= src_ff - IDX_W'(1);
               end else begin
                  mv_dst_ff <= src_ff - shamt_ff[IDX_W-1:0];
                  src_ff    <= src_ff + IDX_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_DECIDE) |-> !mem_we)
      else $error("slot memory written during scan");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted without going busy");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && cmd_ff == CMD_ENQ) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("enqueue did not grow the queue");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for timed_tx_slot_queue_unit: directed table, then random phases.
// Depends on ttsq_pkg and the unit; results are checked against an in-bench queue model or fixed table values.
`timescale 1ns / 1ps

module tb_top;
   import ttsq_pkg::*;

   typedef struct {
      logic [1:0]        cmd;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] t;
      logic [AIR_W-1:0]  air;
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  tag;
      logic [SLOT_W-1:0] idx;
   } sched_cmd_type;

   typedef struct {
      logic [2:0]        status;
      logic              ready;
      logic [OUT_W-1:0]  dropped;
      logic [TAG_W-1:0]  tag;
      logic [KIND_W-1:0] kind;
      logic [OUT_W-1:0]  fill;
   } sched_rsp_type;

   typedef struct {
      sched_cmd_type c;
      bit            fixed;
      status_type    st;
      int            fill;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]        req_cmd = '0;
   logic [TIME_W-1:0] req_now_us = '0;
   logic [TIME_W-1:0] req_send_time_us = '0;
   logic [AIR_W-1:0]  req_airtime_us = '0;
   logic [KIND_W-1:0] req_kind_in = '0;
   logic [TAG_W-1:0]  req_tag_in = '0;
   logic [SLOT_W-1:0] req_slot_index = '0;
   logic              rsp_valid;
   logic [2:0]        rsp_status;
   logic              rsp_head_ready;
   logic [OUT_W-1:0]  rsp_dropped_count;
   logic [TAG_W-1:0]  rsp_tag_out;
   logic [KIND_W-1:0] rsp_kind_out;
   logic [OUT_W-1:0]  rsp_fill_level;
   logic              csr_we = 1'b0;
   logic [CSR_A_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   timed_tx_slot_queue_unit uut (.*);

   always #5 clock = ~clock;

   // Queue model state and timing registers
   longint unsigned m_time [DEPTH];
   longint unsigned m_air  [DEPTH];
   logic [KIND_W-1:0] m_kind [DEPTH];
   logic [TAG_W-1:0]  m_tag  [DEPTH];
   int m_count = 0;
   longint unsigned r_start = 1500, r_jit = 10000, r_margin = 1000;
   longint unsigned r_adv = 6000000, r_dev = 500;

   sched_rsp_type pending_rsp [$];
   int fail_cnt = 0;
   longint unsigned cur_now = 64'd1000000;
   table_row_type rows [$];

   function automatic void drop_slot(int pos);
      for (int k = pos; k + 1 < m_count; k++) begin
         m_time[k] = m_time[k+1];
         m_air[k]  = m_air[k+1];
         m_kind[k] = m_kind[k+1];
         m_tag[k]  = m_tag[k+1];
      end
      m_count--;
   endfunction

   // Works out the result of one command and updates the model
   function automatic sched_rsp_type queue_step(sched_cmd_type c);
      sched_rsp_type r;
      longint unsigned now, t, pre, old;
      bit coll;
      int pos, drops;
      now = c.now;
      t = c.t;
      pre = r_start + r_jit;
      r = '{ST_OK, 1'b0, '0, '0, '0, '0};
      drops = 0;
      case (c.cmd)
         CMD_ENQ: begin
            if (m_count >= DEPTH) r.status = ST_FULL;
            else if (t <= now + r_margin + r_jit) r.status = ST_LATE;
            else if (t >= now + r_adv) r.status = ST_EARLY;
            else begin
               coll = 0;
               for (int k = 0; k < m_count; k++) begin
                  old = m_time[k];
                  if (t <= old) begin
                     if (old - t <= pre + c.air + r_margin) coll = 1;
                  end else if (t - old <= pre + m_air[k] + r_margin) coll = 1;
               end
               if (coll) r.status = ST_COLL;
               else begin
                  pos = 0;
                  while (pos < m_count && m_time[pos] <= t) pos++;
                  for (int k = m_count; k > pos; k--) begin
                     m_time[k] = m_time[k-1];
                     m_air[k]  = m_air[k-1];
                     m_kind[k] = m_kind[k-1];
                     m_tag[k]  = m_tag[k-1];
                  end
                  m_time[pos] = t;
                  m_air[pos]  = c.air;
                  m_kind[pos] = c.kind;
                  m_tag[pos]  = c.tag;
                  m_count++;
               end
            end
         end
         CMD_PEEK: begin
            if (m_count == 0) r.status = ST_EMPTY;
            else begin
               while (m_count > 0 && m_time[0] < now) begin
                  drop_slot(0);
                  drops++;
               end
               if (m_count == 0) r.status = ST_EMPTY;
               else r.ready = (m_time[0] - now) < r_dev;
               r.dropped = OUT_W'(drops);
            end
         end
         CMD_DEQ: begin
            if (m_count == 0) r.status = ST_EMPTY;
            else if (c.idx >= m_count) r.status = ST_BADIDX;
            else begin
               r.tag  = m_tag[c.idx];
               r.kind = m_kind[c.idx];
               drop_slot(c.idx);
            end
         end
         default: ;
      endcase
      r.fill = OUT_W'(m_count);
      return r;
   endfunction

   // Result checker: every strobed result against the oldest expectation
   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result, status %0d", rsp_status);
            fail_cnt++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); fail_cnt++;
            end
            if (rsp_head_ready !== e.ready) begin
               $error("head_ready exp %0d got %0d", e.ready, rsp_head_ready); fail_cnt++;
            end
            if (rsp_dropped_count !== e.dropped) begin
               $error("dropped_count exp %0d got %0d", e.dropped, rsp_dropped_count);
               fail_cnt++;
            end
            if (rsp_tag_out !== e.tag) begin
               $error("tag_out exp %0d got %0d", e.tag, rsp_tag_out); fail_cnt++;
            end
            if (rsp_kind_out !== e.kind) begin
               $error("kind_out exp %0d got %0d", e.kind, rsp_kind_out); fail_cnt++;
            end
            if (rsp_fill_level !== e.fill) begin
               $error("fill_level exp %0d got %0d", e.fill, rsp_fill_level); fail_cnt++;
            end
         end
      end
   end

   // Drive one command and hold it until the transfer; caller sits at a clock edge
   task automatic issue(sched_cmd_type c, bit fixed, status_type st, int fill);
      sched_rsp_type r;
      start <= 1'b1;
      req_cmd <= c.cmd;
      req_now_us <= c.now;
      req_send_time_us <= c.t;
      req_airtime_us <= c.air;
      req_kind_in <= c.kind;
      req_tag_in <= c.tag;
      req_slot_index <= c.idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = queue_step(c);
      if (fixed) r = '{st, 1'b0, '0, '0, '0, fill[OUT_W-1:0]};
      pending_rsp.push_back(r);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);
   endtask

   task automatic write_regs(longint unsigned sd, longint unsigned jd, longint unsigned mg,
                             longint unsigned adv, longint unsigned dev);
      longint unsigned v [5];
      v = '{sd, jd, mg, adv, dev};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= i[CSR_A_W-1:0];
         csr_wdata <= v[i][CSR_W-1:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      r_start  = sd & 64'hFFFFF;
      r_jit    = jd & 64'hFFFFF;
      r_margin = mg & 64'hFFFFF;
      r_adv    = adv & 64'hFFFFFF;
      r_dev    = dev & 64'hFFFFF;
   endtask

   task automatic add_row(logic [1:0] cmd, longint unsigned now, longint unsigned t,
                          logic [AIR_W-1:0] air, logic [7:0] tag, logic [4:0] idx,
                          bit fixed, status_type st, int fill);
      table_row_type w;
      w.c = '{cmd, now[TIME_W-1:0], t[TIME_W-1:0], air, tag[1:0], tag, idx};
      w.fixed = fixed;
      w.st = st;
      w.fill = fill;
      rows.push_back(w);
   endtask

   // Random command: mostly well-formed schedule traffic, some noise
   function automatic sched_cmd_type gen_cmd(int enq_pct);
      sched_cmd_type c;
      int r;
      longint unsigned lo, hi, n;
      c.kind = KIND_W'($urandom);
      c.tag = TAG_W'($urandom);
      c.air = AIR_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000));
      c.idx = SLOT_W'($urandom);
      c.t = TIME_W'({$urandom, $urandom});
      cur_now += $urandom_range(0, 3000);
      n = cur_now;
      r = $urandom_range(0, 99);
      if (r < enq_pct) begin
         c.cmd = CMD_ENQ;
         lo = n + r_margin + r_jit + 1;
         hi = n + r_adv;
         if (hi > lo + 1) lo = lo + ($urandom % (hi - lo));
         c.t = lo[TIME_W-1:0];
      end else if (r < enq_pct + (100 - enq_pct) / 3) begin
         c.cmd = CMD_PEEK;
         if (m_count > 0 && $urandom_range(0, 1)) begin
            if ($urandom_range(0, 1) && m_time[0] > 1500)
               n = m_time[0] - $urandom_range(0, 1500);
            else n = m_time[0] + $urandom_range(0, 30000);
            if (n > cur_now) cur_now = n;
         end
      end else if (r < 92) begin
         c.cmd = CMD_DEQ;
         if (m_count > 0 && $urandom_range(0, 4) != 0)
            c.idx = SLOT_W'($urandom_range(0, m_count - 1));
      end else begin
         c.cmd = 2'($urandom);
         n = {$urandom, $urandom};
      end
      c.now = n[TIME_W-1:0];
      return c;
   endfunction

   initial begin
      longint unsigned n0, tmax;
      int gap_pct, enq_pct;
      n0 = 64'd1000000;
      tmax = 64'hFFFF_FFFF_FFFF;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table: empty queue, bounds, collisions, index range, purge
      add_row(CMD_PEEK, n0, 0, 0, 8'h00, 0, 1, ST_EMPTY, 0);
      add_row(CMD_DEQ, n0, 0, 0, 8'h00, 0, 1, ST_EMPTY, 0);
      add_row(CMD_NOP, n0, 0, 0, 8'h00, 0, 1, ST_OK, 0);
      add_row(CMD_ENQ, n0, n0 + 11000, 0, 8'h11, 0, 1, ST_LATE, 0);
      add_row(CMD_ENQ, n0, n0 + 6000000, 0, 8'h12, 0, 1, ST_EARLY, 0);
      add_row(CMD_ENQ, n0, n0 + 11001, 0, 8'hFF, 0, 1, ST_OK, 1);
      add_row(CMD_ENQ, n0, n0 + 11001, 0, 8'h21, 0, 1, ST_COLL, 1);
      add_row(CMD_ENQ, n0, n0 + 23501, 0, 8'h22, 0, 1, ST_COLL, 1);
      add_row(CMD_ENQ, n0, n0 + 23502, 0, 8'h23, 0, 1, ST_OK, 2);
      add_row(CMD_DEQ, n0, 0, 0, 8'h00, 2, 1, ST_BADIDX, 2);
      add_row(CMD_DEQ, n0, 0, 0, 8'h00, 31, 1, ST_BADIDX, 2);
      add_row(CMD_ENQ, n0, n0 + 5999999, 24'hFFFFFF, 8'h00, 0, 1, ST_OK, 3);
      add_row(CMD_ENQ, n0, n0 + 5999999 - 12501, 0, 8'h5A, 0, 0, ST_OK, 0);
      add_row(CMD_PEEK, n0 + 11001 - 499, 0, 0, 8'h00, 0, 0, ST_OK, 0);
      add_row(CMD_PEEK, n0 + 11001 - 500, 0, 0, 8'h00, 0, 0, ST_OK, 0);
      add_row(CMD_DEQ, n0, 0, 0, 8'h00, 1, 0, ST_OK, 0);
      add_row(CMD_PEEK, n0 + 11002, 0, 0, 8'h00, 0, 0, ST_OK, 0);
      add_row(CMD_PEEK, tmax, 0, 0, 8'h00, 0, 0, ST_OK, 0);
      add_row(CMD_ENQ, tmax, tmax, 0, 8'h33, 0, 1, ST_LATE, 0);
      add_row(CMD_ENQ, 0, tmax, 24'hFFFFFF, 8'hC3, 0, 1, ST_EARLY, 0);
      add_row(CMD_NOP, tmax, tmax, 24'hFFFFFF, 8'hFF, 31, 0, ST_OK, 0);
      foreach (rows[i]) issue(rows[i].c, rows[i].fixed, rows[i].st, rows[i].fill);
      wait_idle();

      // Random phases, each with a timing register setting and a pacing
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_regs(1500, 10000, 1000, 6000000, 500);
               gap_pct = 0; enq_pct = 45;
            end
            1: begin write_regs(0, 0, 0, 24'hFFFFFF, 20'hFFFFF); gap_pct = 53; enq_pct = 75; end
            2: begin
               write_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 20'hFFFFF);
               gap_pct = 23; enq_pct = 50;
            end
            3: begin write_regs(0, 0, 0, 0, 0); gap_pct = 0; enq_pct = 40; end
            4: begin
               write_regs($urandom_range(0, 20000), $urandom_range(0, 20000),
                          $urandom_range(0, 5000), $urandom_range(100000, 9000000),
                          $urandom_range(0, 5000));
               gap_pct = 53; enq_pct = 55;
            end
            default: begin
               write_regs(1500, 10000, 1000, 6000000, 500);
               gap_pct = 23; enq_pct = 70;
            end
         endcase
         for (int i = 0; i < 150; i++) begin
            issue(gen_cmd(enq_pct), 0, ST_OK, 0);
            if ($urandom_range(0, 99) < gap_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end
         end
         wait_idle();
      end

      if (fail_cnt == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Run-time limit
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/ttsq_pkg.sv
hdl/timed_tx_slot_queue_unit.sv
bench/tb_top.sv
